/* hw/rtl/vtp_pkg.sv */
// ---------------------------------------------------------------------------
// vtp_pkg
// Shared types, constants and helpers for the velocity to position core.
// ---------------------------------------------------------------------------
package vtp_pkg;

    localparam int DATA_W    = 32;            // Q16.16 word
    localparam int CFG_W     = 31;            // unsigned configuration fields
    localparam int FRAC_W    = 16;            // fraction bits of Q16.16
    localparam int WIDE_W    = 49;            // sum of a word and a shifted product
    localparam int PROD_W    = 64;            // product register
    localparam int DIV_CNT_W = $clog2(FRAC_W);
    localparam int RATE_W    = FRAC_W + 1;    // rate in [0, 1.0]
    localparam int ADDR_W    = 5;
    localparam int IDX_W     = 3;

    localparam logic [CFG_W-1:0]  VEL_LIMIT_RST      = 31'd65536;
    localparam logic [DATA_W-1:0] UPPER_LIMIT_RST    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] LOWER_LIMIT_RST    = 32'h8000_0000;
    localparam logic [CFG_W-1:0]  STEP_TIME_RST      = 31'd3277;
    localparam logic [CFG_W-1:0]  UPDATE_DELAY_RST   = 31'd32768;
    localparam logic [CFG_W-1:0]  PUBLISH_PERIOD_RST = 31'd2185;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << FRAC_W;

    typedef enum logic [IDX_W-1:0] {
        REG_VEL_LIMIT      = 3'd0,
        REG_UPPER_LIMIT    = 3'd1,
        REG_LOWER_LIMIT    = 3'd2,
        REG_STEP_TIME      = 3'd3,
        REG_UPDATE_DELAY   = 3'd4,
        REG_PUBLISH_PERIOD = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]         vel_limit;
        logic signed [DATA_W-1:0] upper_limit;
        logic signed [DATA_W-1:0] lower_limit;
        logic [CFG_W-1:0]         step_time;
        logic [CFG_W-1:0]         update_delay;
        logic [CFG_W-1:0]         publish_period;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_FLAGS,
        OP_DIV,
        OP_ADV_MUL,
        OP_ADV_ADD,
        OP_STEP_MUL,
        OP_STEP_ADD,
        OP_CLAMP,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
        logic   out_gated;
    } dp_cmd_t;

    typedef struct packed {
        logic gated;
        logic resync;
        logic full_rate;
    } dp_status_t;

    // saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_to_32(input logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (&x[WIDE_W-1:DATA_W-1] || ~|x[WIDE_W-1:DATA_W-1])
        begin
            r = x[DATA_W-1:0];
        end
        else if (x[WIDE_W-1])
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/vtp_config.sv */
// ---------------------------------------------------------------------------
// vtp_config
// Register bank behind the APB-style port: write decode, masking, readback.
// ---------------------------------------------------------------------------
module vtp_config (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [vtp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output vtp_pkg::cfg_t            cfg
);
    import vtp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vel_limit      <= VEL_LIMIT_RST;
            cfg_reg.upper_limit    <= UPPER_LIMIT_RST;
            cfg_reg.lower_limit    <= LOWER_LIMIT_RST;
            cfg_reg.step_time      <= STEP_TIME_RST;
            cfg_reg.update_delay   <= UPDATE_DELAY_RST;
            cfg_reg.publish_period <= PUBLISH_PERIOD_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_VEL_LIMIT:      cfg_reg.vel_limit      <= pwdata[CFG_W-1:0];
                REG_UPPER_LIMIT:    cfg_reg.upper_limit    <= pwdata;
                REG_LOWER_LIMIT:    cfg_reg.lower_limit    <= pwdata;
                REG_STEP_TIME:      cfg_reg.step_time      <= pwdata[CFG_W-1:0];
                REG_UPDATE_DELAY:   cfg_reg.update_delay   <= pwdata[CFG_W-1:0];
                REG_PUBLISH_PERIOD: cfg_reg.publish_period <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_VEL_LIMIT:      prdata = {1'b0, cfg_reg.vel_limit};
            REG_UPPER_LIMIT:    prdata = cfg_reg.upper_limit;
            REG_LOWER_LIMIT:    prdata = cfg_reg.lower_limit;
            REG_STEP_TIME:      prdata = {1'b0, cfg_reg.step_time};
            REG_UPDATE_DELAY:   prdata = {1'b0, cfg_reg.update_delay};
            REG_PUBLISH_PERIOD: prdata = {1'b0, cfg_reg.publish_period};
            default:            prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/vtp_ctrl.sv */
// ---------------------------------------------------------------------------
// vtp_ctrl
// Sequencer: steps the datapath through one request and owns both handshakes.
// ---------------------------------------------------------------------------
module vtp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  vtp_pkg::dp_status_t status,
    output vtp_pkg::dp_cmd_t    cmd
);
    import vtp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_FLAGS,
        S_DIV,
        S_ADV_MUL,
        S_ADV_ADD,
        S_STEP_MUL,
        S_STEP_ADD,
        S_CLAMP,
        S_COMMIT,
        S_OUTPUT
    } state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 gated_reg;
    logic                 out_valid_reg;
    logic                 out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = ~out_valid_reg | out_ready;

    always_comb
    begin
        cmd.out_load  = 1'b0;
        cmd.out_gated = gated_reg;
        case (state_reg)
            S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_PREP:     cmd.op = OP_PREP;
            S_FLAGS:    cmd.op = OP_FLAGS;
            S_DIV:      cmd.op = OP_DIV;
            S_ADV_MUL:  cmd.op = OP_ADV_MUL;
            S_ADV_ADD:  cmd.op = OP_ADV_ADD;
            S_STEP_MUL: cmd.op = OP_STEP_MUL;
            S_STEP_ADD: cmd.op = OP_STEP_ADD;
            S_CLAMP:    cmd.op = OP_CLAMP;
            S_COMMIT:   cmd.op = OP_COMMIT;
            S_OUTPUT:
            begin
                cmd.op       = OP_NONE;
                cmd.out_load = out_free;
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            gated_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // raise valid as a result loads, else drop it once the sink takes it
            if (state_reg == S_OUTPUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        gated_reg <= 1'b0;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_FLAGS;
                end
                S_FLAGS:
                begin
                    div_cnt_reg <= '0;
                    if (status.gated)
                    begin
                        gated_reg <= 1'b1;
                        state_reg <= S_OUTPUT;
                    end
                    else if (status.resync)
                    begin
                        state_reg <= S_STEP_MUL;
                    end
                    else if (status.full_rate)
                    begin
                        state_reg <= S_ADV_MUL;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (&div_cnt_reg)
                    begin
                        state_reg <= S_ADV_MUL;
                    end
                end
                S_ADV_MUL:  state_reg <= S_ADV_ADD;
                S_ADV_ADD:  state_reg <= S_STEP_MUL;
                S_STEP_MUL: state_reg <= S_STEP_ADD;
                S_STEP_ADD: state_reg <= S_CLAMP;
                S_CLAMP:    state_reg <= S_COMMIT;
                S_COMMIT:   state_reg <= S_OUTPUT;
                S_OUTPUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/vtp_datapath.sv */
// ---------------------------------------------------------------------------
// vtp_datapath
// Operand registers, product register, radix-2 divider, clamps, joint state.
// ---------------------------------------------------------------------------
module vtp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vtp_pkg::cfg_t                     cfg,
    input  vtp_pkg::dp_cmd_t                  cmd,
    input  logic [vtp_pkg::DATA_W-1:0]        in_timestamp,
    input  logic signed [vtp_pkg::DATA_W-1:0] in_measured_position,
    input  logic signed [vtp_pkg::DATA_W-1:0] in_velocity_cmd,
    output vtp_pkg::dp_status_t               status,
    output logic                              out_published,
    output logic signed [vtp_pkg::DATA_W-1:0] out_command_position
);
    import vtp_pkg::*;

    // item operands
    logic [DATA_W-1:0]        ts_reg;
    logic signed [DATA_W-1:0] meas_reg;
    logic signed [DATA_W-1:0] vel_reg;
    // working registers
    logic [DATA_W-1:0]        elapsed_reg;
    logic signed [DATA_W-1:0] vclamp_reg;
    logic signed [DATA_W+1:0] ub_wide_reg;
    logic signed [DATA_W+1:0] lb_wide_reg;
    logic signed [DATA_W-1:0] ub_reg;
    logic signed [DATA_W-1:0] lb_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic signed [DATA_W-1:0] local_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] cmd_wide_reg;
    logic signed [DATA_W-1:0] result_reg;
    // joint state
    logic signed [DATA_W-1:0] local_position_reg;
    logic signed [DATA_W-1:0] last_step_reg;
    logic [DATA_W-1:0]        last_time_reg;
    // result register
    logic                     published_reg;
    logic signed [DATA_W-1:0] command_reg;

    logic signed [DATA_W+1:0] half;
    logic signed [DATA_W+1:0] meas_x;
    logic signed [DATA_W:0]   mv_x;
    logic signed [DATA_W:0]   vel_x;
    logic signed [DATA_W-1:0] vclamp;
    logic signed [DATA_W-1:0] ub_sel;
    logic signed [DATA_W-1:0] lb_sel;
    logic [DATA_W-1:0]        trial;
    logic [DATA_W-1:0]        step_x;
    logic                     trial_ge;
    logic signed [WIDE_W+1:0] adv_prod;
    logic signed [PROD_W-1:0] step_prod;
    logic signed [WIDE_W-1:0] shifted_x;
    logic signed [WIDE_W-1:0] adv_sum;
    logic signed [WIDE_W-1:0] step_sum;
    logic signed [WIDE_W-1:0] ub_x;
    logic signed [WIDE_W-1:0] lb_x;
    logic signed [WIDE_W-1:0] diff_x;

    assign status.gated     = elapsed_reg < {1'b0, cfg.publish_period};
    assign status.resync    = elapsed_reg >= {1'b0, cfg.update_delay};
    assign status.full_rate = elapsed_reg >= {1'b0, cfg.step_time};

    assign out_published        = published_reg;
    assign out_command_position = command_reg;

    always_comb
    begin
        half   = $signed({4'b0000, cfg.vel_limit[CFG_W-1:1]});
        meas_x = {{2{meas_reg[DATA_W-1]}}, meas_reg};
        mv_x   = $signed({2'b00, cfg.vel_limit});
        vel_x  = {vel_reg[DATA_W-1], vel_reg};
        if (vel_x > mv_x)
        begin
            vclamp = mv_x[DATA_W-1:0];
        end
        else if (vel_x < -mv_x)
        begin
            vclamp = DATA_W'(-mv_x);
        end
        else
        begin
            vclamp = vel_reg;
        end

        ub_sel = ($signed({{2{cfg.upper_limit[DATA_W-1]}}, cfg.upper_limit})
                  < ub_wide_reg) ? cfg.upper_limit : ub_wide_reg[DATA_W-1:0];
        lb_sel = ($signed({{2{cfg.lower_limit[DATA_W-1]}}, cfg.lower_limit})
                  > lb_wide_reg) ? cfg.lower_limit : lb_wide_reg[DATA_W-1:0];

        // one restoring divide step; remainder stays below step_time
        step_x   = {1'b0, cfg.step_time};
        trial    = {rem_reg[DATA_W-2:0], 1'b0};
        trial_ge = trial >= step_x;

        adv_prod  = $signed({1'b0, rate_reg}) * last_step_reg;
        step_prod = vclamp_reg * $signed(step_x);
        shifted_x = {{(WIDE_W-(PROD_W-FRAC_W)){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FRAC_W]};
        adv_sum   = {{(WIDE_W-DATA_W){local_position_reg[DATA_W-1]}}, local_position_reg}
                    + shifted_x;
        step_sum  = {{(WIDE_W-DATA_W){local_reg[DATA_W-1]}}, local_reg} + shifted_x;

        ub_x   = {{(WIDE_W-DATA_W){ub_reg[DATA_W-1]}}, ub_reg};
        lb_x   = {{(WIDE_W-DATA_W){lb_reg[DATA_W-1]}}, lb_reg};
        diff_x = {{(WIDE_W-DATA_W){result_reg[DATA_W-1]}}, result_reg}
                 - {{(WIDE_W-DATA_W){local_reg[DATA_W-1]}}, local_reg};
    end

    // joint state: reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_position_reg <= '0;
            last_step_reg      <= '0;
            last_time_reg      <= '0;
        end
        else if (cmd.op == OP_COMMIT)
        begin
            local_position_reg <= local_reg;
            last_step_reg      <= sat_to_32(diff_x);
            last_time_reg      <= ts_reg;
        end
    end

    // working registers: payload only
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ts_reg   <= in_timestamp;
                meas_reg <= in_measured_position;
                vel_reg  <= in_velocity_cmd;
            end
            OP_PREP:
            begin
                elapsed_reg <= ts_reg - last_time_reg;
                vclamp_reg  <= vclamp;
                ub_wide_reg <= meas_x + half;
                lb_wide_reg <= meas_x - half;
            end
            OP_FLAGS:
            begin
                ub_reg    <= ub_sel;
                lb_reg    <= lb_sel;
                local_reg <= meas_reg;
                rem_reg   <= elapsed_reg;
                rate_reg  <= status.full_rate ? RATE_ONE : '0;
            end
            OP_DIV:
            begin
                rem_reg  <= trial_ge ? (trial - step_x) : trial;
                rate_reg <= {rate_reg[RATE_W-2:0], trial_ge};
            end
            OP_ADV_MUL:
            begin
                prod_reg <= {{(PROD_W-WIDE_W-2){adv_prod[WIDE_W+1]}}, adv_prod};
            end
            OP_ADV_ADD:
            begin
                local_reg <= sat_to_32(adv_sum);
            end
            OP_STEP_MUL:
            begin
                prod_reg <= step_prod;
            end
            OP_STEP_ADD:
            begin
                cmd_wide_reg <= step_sum;
            end
            OP_CLAMP:
            begin
                if (cmd_wide_reg > ub_x)
                begin
                    result_reg <= ub_reg;
                end
                else if (cmd_wide_reg < lb_x)
                begin
                    result_reg <= lb_reg;
                end
                else
                begin
                    result_reg <= sat_to_32(cmd_wide_reg);
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            published_reg <= ~cmd.out_gated;
            command_reg   <= cmd.out_gated ? '0 : result_reg;
        end
    end

endmodule

/* hw/rtl/velocity_to_position_command.sv */
// ---------------------------------------------------------------------------
// velocity_to_position_command_core
// Single-joint pseudo-velocity controller, Q16.16: gate, resync or advance
// the local position, integrate the clamped velocity, clamp to the limits.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ---------------------------------
//  s_axis    in         tvalid / tready    tdata: timestamp, measured_position,
//                                          velocity_cmd
//  m_axis    out        tvalid / tready    tdata: command_position,
//                                          tuser: published
//  apb       in         psel/penable/pwr.  6 registers at 4*i, pready tied high
//
//  One request at a time. A gated request goes from its flags step to the
//  output step; a resync skips the advance, an advance at full rate skips
//  the divider; the elapsed-time ratio needs the radix-2 divider first.
//  The next request is accepted in the cycle after the result is loaded.
//  The result register holds while m_axis_tready is low; the sequencer then
//  waits in its output step. Reset clears control and the joint state.
//
module velocity_to_position_command_core (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] timestamp, [63:32] measured_position, [95:64] velocity_cmd
    input  logic [95:0]                s_axis_tdata,
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [31:0] command_position
    output logic [31:0]                m_axis_tdata,
    // [0] published
    output logic                       m_axis_tuser,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vtp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import vtp_pkg::*;

    cfg_t                     cfg;
    dp_cmd_t                  cmd;
    dp_status_t               status;
    logic signed [DATA_W-1:0] command_position;

    // configuration registers; user must write only between requests, unguarded
    vtp_config u_config (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accepts a request, steps the datapath, loads the result
    vtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and joint state; captures the payload on the load command
    vtp_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .cmd                  (cmd),
        .in_timestamp         (s_axis_tdata[31:0]),
        .in_measured_position (s_axis_tdata[63:32]),
        .in_velocity_cmd      (s_axis_tdata[95:64]),
        .status               (status),
        .out_published        (m_axis_tuser),
        .out_command_position (command_position)
    );

    assign m_axis_tdata = command_position;

endmodule

/* tb/tb_velocity_to_position_command_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_velocity_to_position_command_core
// Drives timestamped position/velocity requests into the core through its
// input stream. An in-bench model of the joint controller predicts every
// published or gated command. Each result on the output stream is compared
// with the oldest prediction. Register settings change between phases, from
// the reset values to the extremes. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_velocity_to_position_command_core;

    import vtp_pkg::*;

    localparam int     CLK_PERIOD     = 20;
    localparam int     RESET_CYCLES   = 11;
    localparam int     IDLE_PERCENT   = 11;
    localparam int     MAX_GAP        = 40;
    localparam int     RANDOM_PHASES  = 6;
    localparam int     PHASE_REQUESTS = 64;
    localparam int     DRAIN_CYCLES   = 40;
    localparam int     REPORT_LIMIT   = 10;
    localparam longint WORD_MAX       = 64'sd2147483647;
    localparam longint WORD_MIN       = -64'sd2147483648;

    // one predicted command: published flag and position
    typedef struct packed {
        logic                     published;
        logic signed [DATA_W-1:0] position;
    } joint_cmd_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [31:0] timestamp, [63:32] measured_position, [95:64] velocity_cmd
    logic [95:0]         s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [31:0] command_position
    logic [31:0]         m_axis_tdata;
    // [0] published
    logic                m_axis_tuser;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    // register mirror, written alongside the APB writes
    logic [CFG_W-1:0]         cfg_vel_limit      = VEL_LIMIT_RST;
    logic signed [DATA_W-1:0] cfg_upper_limit    = UPPER_LIMIT_RST;
    logic signed [DATA_W-1:0] cfg_lower_limit    = LOWER_LIMIT_RST;
    logic [CFG_W-1:0]         cfg_step_time      = STEP_TIME_RST;
    logic [CFG_W-1:0]         cfg_update_delay   = UPDATE_DELAY_RST;
    logic [CFG_W-1:0]         cfg_publish_period = PUBLISH_PERIOD_RST;

    // joint state of the model
    logic signed [DATA_W-1:0] joint_local    = '0;
    logic signed [DATA_W-1:0] joint_step     = '0;
    logic [DATA_W-1:0]        joint_pub_time = '0;

    joint_cmd_t  pending_cmds[$];
    bit          pacing_enable   = 1'b1;
    int unsigned failure_count   = 0;
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned published_seen  = 0;
    int unsigned register_writes = 0;
    logic [31:0] ts_cursor       = '0;

    velocity_to_position_command_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop well beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // model
    // -----------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] sat_word(input longint x);
        if (x > WORD_MAX)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (x < WORD_MIN)
        begin
            return 32'sh8000_0000;
        end
        return x[DATA_W-1:0];
    endfunction

    // Work out the command for one accepted request and advance the joint
    // state. Gated requests leave the state alone and report position zero.
    function automatic joint_cmd_t predict_joint_cmd(input logic [31:0] ts,
                                                     input logic signed [31:0] meas,
                                                     input logic signed [31:0] vel);
        logic [DATA_W-1:0]        elapsed;
        longint                   elapsed_l, meas_l, vel_l, mv, st;
        longint                   rate, local_l, cmd, ub, lb, half;
        logic signed [DATA_W-1:0] local_w;
        joint_cmd_t               r;
        r         = '0;
        elapsed   = ts - joint_pub_time;
        elapsed_l = elapsed;
        meas_l    = meas;
        vel_l     = vel;
        mv        = cfg_vel_limit;
        st        = cfg_step_time;
        if (elapsed < cfg_publish_period)
        begin
            return r;
        end
        // resync after a long idle, else advance by a share of the last step
        if (elapsed >= cfg_update_delay)
        begin
            local_w = meas;
        end
        else
        begin
            if (elapsed >= cfg_step_time)
            begin
                rate = 65536;
            end
            else
            begin
                rate = (elapsed_l << 16) / st;
            end
            local_w = sat_word(longint'(joint_local) + ((rate * longint'(joint_step)) >>> 16));
        end
        local_l = local_w;
        if (vel_l > mv)
        begin
            vel_l = mv;
        end
        else if (vel_l < -mv)
        begin
            vel_l = -mv;
        end
        cmd  = local_l + ((vel_l * st) >>> 16);
        half = mv / 2;
        ub   = meas_l + half;
        if (longint'(cfg_upper_limit) < ub)
        begin
            ub = cfg_upper_limit;
        end
        lb = meas_l - half;
        if (longint'(cfg_lower_limit) > lb)
        begin
            lb = cfg_lower_limit;
        end
        // upper bound is tested first when the bounds cross
        if (cmd > ub)
        begin
            cmd = ub;
        end
        else if (cmd < lb)
        begin
            cmd = lb;
        end
        r.published    = 1'b1;
        r.position     = sat_word(cmd);
        joint_local    = local_w;
        joint_step     = sat_word(longint'(r.position) - local_l);
        joint_pub_time = ts;
        return r;
    endfunction

    function automatic logic [31:0] register_image(input reg_idx_t idx);
        case (idx)
            REG_VEL_LIMIT:      return {1'b0, cfg_vel_limit};
            REG_UPPER_LIMIT:    return cfg_upper_limit;
            REG_LOWER_LIMIT:    return cfg_lower_limit;
            REG_STEP_TIME:      return {1'b0, cfg_step_time};
            REG_UPDATE_DELAY:   return {1'b0, cfg_update_delay};
            REG_PUBLISH_PERIOD: return {1'b0, cfg_publish_period};
            default:            return '0;
        endcase
    endfunction

    task automatic note_failure(input string what);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
        begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // -----------------------------------------------------------------------
    // result side: check every accepted command, stall at random
    // -----------------------------------------------------------------------
    task automatic check_command(input logic published, input logic [31:0] position);
        joint_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            note_failure($sformatf("unexpected command published=%0b position=%h",
                                   published, position));
        end
        else
        begin
            want = pending_cmds.pop_front();
            results_checked++;
            if (published)
            begin
                published_seen++;
            end
            if (published !== want.published || position !== want.position)
            begin
                note_failure($sformatf(
                    "command %0d: expected published=%0b position=%h, got published=%0b position=%h",
                    results_checked, want.published, want.position, published, position));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_command(m_axis_tuser, m_axis_tdata);
        end
        m_axis_tready <= !(pacing_enable && $urandom_range(99) < IDLE_PERCENT);
    end

    // -----------------------------------------------------------------------
    // request side
    // -----------------------------------------------------------------------
    // Present one request and hold it until accepted; valid stays high so the
    // next request can follow back to back.
    task automatic send_request(input logic [31:0] ts,
                                input logic signed [31:0] meas,
                                input logic signed [31:0] vel);
        int unsigned gap;
        joint_cmd_t  predicted;
        if (pacing_enable && $urandom_range(99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, MAX_GAP);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vel, meas, ts};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted    = predict_joint_cmd(ts, meas, vel);
        pending_cmds = {pending_cmds, predicted};
        requests_sent++;
        ts_cursor = ts;
    endtask

    // Drop valid and wait until every command is back and the core is ready.
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0 || !s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // -----------------------------------------------------------------------
    // configuration port
    // -----------------------------------------------------------------------
    task automatic read_register(input reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== register_image(idx))
        begin
            note_failure($sformatf("register %s: expected %h, read %h",
                                   idx.name(), register_image(idx), prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write one register while the core is idle, then read it back.
    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        drain_requests();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_VEL_LIMIT:      cfg_vel_limit      = value[CFG_W-1:0];
            REG_UPPER_LIMIT:    cfg_upper_limit    = value;
            REG_LOWER_LIMIT:    cfg_lower_limit    = value;
            REG_STEP_TIME:      cfg_step_time      = value[CFG_W-1:0];
            REG_UPDATE_DELAY:   cfg_update_delay   = value[CFG_W-1:0];
            REG_PUBLISH_PERIOD: cfg_publish_period = value[CFG_W-1:0];
            default:            ;
        endcase
        register_writes++;
        read_register(idx);
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    task automatic test_register_defaults();
        reg_idx_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            read_register(idx);
            idx = idx.next();
        end
    endtask

    // The first request meets a publish at time zero: gate it, then publish
    // through the divider, at full rate and after a resync.
    task automatic test_first_publish();
        send_request(32'd0,     32'sh0001_0000, 32'sh0000_8000);
        send_request(32'd2184,  32'sh0001_0000, 32'sh0000_8000);
        send_request(32'd2185,  32'sh0001_0000, 32'sh0000_8000);
        send_request(32'd4685,  32'sh0001_0400, -32'sh0000_C000);
        send_request(32'd7962,  32'sh0001_2000, 32'sh0001_0000);
        send_request(32'd47962, 32'sh0000_2000, 32'sh0002_0000);
    endtask

    // Extremes of every field and a timestamp that wraps forward and back.
    task automatic test_field_extremes();
        send_request(32'h1000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(32'h2000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_request(32'hFFFF_FFFF, 32'sh0000_0000, 32'sh0000_FFFF);
        send_request(32'h0000_0500, 32'sh0000_1000, 32'sh0000_4000);
        send_request(32'h0000_1000, 32'sh0000_1000, 32'sh0000_4000);
        send_request(32'h0000_0800, -32'sh0000_3000, -32'sh0000_4000);
    endtask

    task automatic test_register_corners();
        // no gating, no step, resync on every request, widest velocity
        write_register(REG_VEL_LIMIT, 32'hFFFF_FFFF);
        write_register(REG_PUBLISH_PERIOD, 32'd0);
        write_register(REG_STEP_TIME, 32'd0);
        write_register(REG_UPDATE_DELAY, 32'd0);
        send_request(32'h0000_0100, 32'sh4000_0000, 32'sh8000_0000);
        send_request(32'h0000_0100, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // advance at full rate with a zero step
        write_register(REG_UPDATE_DELAY, 32'h7FFF_FFFF);
        send_request(32'h0000_0105, 32'sh0000_0000, 32'sh1234_5678);
        // huge step time: divider with a tiny ratio, then saturation
        write_register(REG_STEP_TIME, 32'hFFFF_FFFF);
        send_request(32'h0000_010F, 32'sh7FFF_0000, 32'sh7FFF_FFFF);
        send_request(32'h4000_010F, -32'sh7FFF_0000, 32'sh8000_0000);
        // crossed bounds: upper below lower
        write_register(REG_VEL_LIMIT, 32'h0001_0000);
        write_register(REG_UPPER_LIMIT, 32'hFFFF_0000);
        write_register(REG_LOWER_LIMIT, 32'h0001_0000);
        write_register(REG_STEP_TIME, 32'd3277);
        write_register(REG_UPDATE_DELAY, 32'd32768);
        write_register(REG_PUBLISH_PERIOD, 32'd2185);
        send_request(32'h5000_0000, 32'sh0000_0000, 32'sh0000_8000);
        send_request(32'h5000_1000, 32'sh0000_0000, -32'sh0000_8000);
        send_request(32'h5000_2000, 32'sh0003_0000, 32'sh0000_0000);
        // zero velocity limit
        write_register(REG_VEL_LIMIT, 32'd0);
        write_register(REG_UPPER_LIMIT, 32'h7FFF_FFFF);
        write_register(REG_LOWER_LIMIT, 32'h8000_0000);
        send_request(32'h5000_3000, 32'sh0001_0000, 32'sh7FFF_FFFF);
        send_request(32'h5000_3C00, 32'sh0001_8000, 32'sh8000_0000);
    endtask

    // Draw a register value: extremes, full range or a plausible setting.
    // Bit 31 of the unsigned registers is random and must be dropped.
    task automatic randomize_registers();
        int unsigned pick;
        logic [31:0] lim;
        pick = $urandom_range(9);
        write_register(REG_VEL_LIMIT, {1'($urandom_range(1)), 31'(
            pick == 0 ? 0 : pick == 1 ? 32'h7FFF_FFFF : pick < 4 ? $urandom :
            $urandom_range(1, 32'h8_0000))});
        pick = $urandom_range(9);
        lim  = $urandom_range(0, 32'h6_0000);
        case (pick)
            0:
            begin
                write_register(REG_UPPER_LIMIT, 32'h7FFF_FFFF);
                write_register(REG_LOWER_LIMIT, 32'h8000_0000);
            end
            1:
            begin
                write_register(REG_UPPER_LIMIT, -lim);
                write_register(REG_LOWER_LIMIT, lim);
            end
            2:
            begin
                write_register(REG_UPPER_LIMIT, $urandom);
                write_register(REG_LOWER_LIMIT, $urandom);
            end
            default:
            begin
                write_register(REG_UPPER_LIMIT, lim);
                write_register(REG_LOWER_LIMIT, -$urandom_range(0, 32'h6_0000));
            end
        endcase
        pick = $urandom_range(9);
        write_register(REG_STEP_TIME, {1'($urandom_range(1)), 31'(
            pick == 0 ? 0 : pick == 1 ? 1 : pick == 2 ? 32'h7FFF_FFFF :
            pick == 3 ? $urandom : $urandom_range(1000, 20000))});
        pick = $urandom_range(9);
        write_register(REG_UPDATE_DELAY, {1'($urandom_range(1)), 31'(
            pick == 0 ? 0 : pick == 1 ? 1 : pick == 2 ? 32'h7FFF_FFFF :
            pick == 3 ? $urandom : $urandom_range(8000, 80000))});
        pick = $urandom_range(11);
        write_register(REG_PUBLISH_PERIOD, {1'($urandom_range(1)), 31'(
            pick == 0 ? 0 : pick == 1 ? 32'h7FFF_FFFF : pick == 2 ? $urandom :
            $urandom_range(500, 4000))});
    endtask

    // Mostly plausible command streams: time steps that land on the gate,
    // the divider, full rate and resync; the rest is full-range noise.
    task automatic send_random_request();
        int unsigned pick;
        logic [31:0] delta, span;
        longint      mv, v, m;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            delta = $urandom_range(0, cfg_publish_period);
        end
        else if (pick < 40)
        begin
            delta = $urandom_range(cfg_publish_period, cfg_step_time);
        end
        else if (pick < 70)
        begin
            delta = $urandom_range(cfg_step_time, cfg_update_delay);
        end
        else if (pick < 88)
        begin
            delta = cfg_update_delay + $urandom_range(0, 32'h1_0000);
        end
        else
        begin
            delta = $urandom;
        end
        mv = cfg_vel_limit;
        if ($urandom_range(99) < 70)
        begin
            span = (mv + mv / 4 + 1 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(mv + mv / 4 + 1);
            v    = $urandom_range(0, span);
            if ($urandom_range(1))
            begin
                v = -v;
            end
        end
        else
        begin
            v = $signed($urandom);
        end
        if ($urandom_range(99) < 85)
        begin
            m = longint'(joint_local) + longint'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
        end
        else
        begin
            m = $signed($urandom);
        end
        send_request(ts_cursor + delta, sat_word(m), sat_word(v));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // phase 0 runs the reset settings, phase 1 runs with no idling
            pacing_enable = (phase != 1);
            if (phase == 0)
            begin
                write_register(REG_VEL_LIMIT, VEL_LIMIT_RST);
                write_register(REG_UPPER_LIMIT, UPPER_LIMIT_RST);
                write_register(REG_LOWER_LIMIT, LOWER_LIMIT_RST);
                write_register(REG_STEP_TIME, STEP_TIME_RST);
                write_register(REG_UPDATE_DELAY, UPDATE_DELAY_RST);
                write_register(REG_PUBLISH_PERIOD, PUBLISH_PERIOD_RST);
            end
            else
            begin
                randomize_registers();
            end
            repeat (PHASE_REQUESTS)
            begin
                send_random_request();
            end
        end
        pacing_enable = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_first_publish();
        test_field_extremes();
        test_register_corners();
        test_random_traffic();

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_cmds.size() != 0)
        begin
            note_failure($sformatf("%0d commands never arrived", pending_cmds.size()));
        end

        $display("Sent %0d requests under %0d register writes; %0d commands checked, %0d published.",
                 requests_sent, register_writes, results_checked, published_seen);
        $display("Mismatches and protocol errors: %0d.", failure_count);
        if (failure_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_config.sv
hw/rtl/vtp_ctrl.sv
hw/rtl/vtp_datapath.sv
hw/rtl/velocity_to_position_command.sv
tb/tb_velocity_to_position_command_core.sv
